// ----- hdl/fbm_pkg.sv -----
// Shared constants and types for the frame border measurement block.
package fbm_pkg;

    // Field widths
    localparam int PIXEL_W   = 32;
    localparam int BAND_W    = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Result tdata: top, bottom, left, right bands, then border colour
    localparam int M_DATA_W  = 4 * BAND_W + PIXEL_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'd0,
        REG_FRAME_HEIGHT = 1'd1
    } t_cfg_reg;

    // Reset frame size
    localparam int RST_WIDTH  = 256;
    localparam int RST_HEIGHT = 240;

endpackage

// ----- hdl/frame_border_measure.sv -----
// Letterbox border measurement over one raster-order frame.
//
// Usage:
//   Pixels enter on the s_ stream group, one 32-bit pixel per request, in
//   raster order. The first pixel of a frame sets the border colour. After
//   the frame's last pixel (width x height from the configuration port) one
//   result leaves on the m_ group: four 12-bit band counts and the colour in
//   m_tdata, the blank flag in m_tuser.
//   Configuration writes (index 0 width, index 1 height) are always taken,
//   abandon any frame in progress and are meant to happen between frames.
//   Size 0 acts as 1; sizes above MAX_WIDTH / MAX_HEIGHT act as the maximum.
// Timing:
//   One pixel per clock while ready. The result of a frame is valid on the
//   cycle after its last pixel is taken. Each pixel needs one 32-bit compare
//   and the min/max tracker updates, all done in the cycle it is taken.
//   While a result waits for m_tready, pixels keep flowing; only the next
//   frame's last pixel is held off until the result register is free.
// Reset:
//   Synchronous, active low. Clears frame state, drops any pending result
//   and restores a 256 x 240 frame size.
module frame_border_measure #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbm_pkg::CFG_W-1:0]       i_cfg_data,
    // Pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbm_pkg::PIXEL_W-1:0]     s_tdata,   // [31:0] pixel
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [11:0] top_band, [23:12] bottom_band, [35:24] left_band,
    // [47:36] right_band, [79:48] border_colour
    output logic [fbm_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tuser    // [0] is_blank
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_WM1 = (fbm_pkg::RST_WIDTH > MAX_WIDTH) ?
                             MAX_WIDTH - 1 : fbm_pkg::RST_WIDTH - 1;
    localparam int RST_HM1 = (fbm_pkg::RST_HEIGHT > MAX_HEIGHT) ?
                             MAX_HEIGHT - 1 : fbm_pkg::RST_HEIGHT - 1;

    // Clamped size minus one, kept from the last write
    logic [CW-1:0] r_wm1, n_wm1;
    logic [RW-1:0] r_hm1, n_hm1;

    // Frame state
    logic [fbm_pkg::PIXEL_W-1:0] r_colour;
    logic [CW-1:0]               r_col, r_min_col, r_max_col;
    logic [RW-1:0]               r_row, r_min_row, r_max_row;
    logic                        r_found;
    logic [CW-1:0]               n_min_col, n_max_col;
    logic [RW-1:0]               n_min_row, n_max_row;

    // Result register
    logic                         r_out_valid;
    logic [fbm_pkg::M_DATA_W-1:0] r_out_data;
    logic                         r_out_blank;

    logic                        w_cfg_acc;
    logic                        w_accept;
    logic                        w_first;
    logic                        w_row_end;
    logic                        w_last;
    logic                        w_diff;
    logic [fbm_pkg::PIXEL_W-1:0] w_colour;
    logic [fbm_pkg::BAND_W-1:0]  w_top, w_bottom, w_left, w_right;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;

    // Frame position; last depends on counters and size registers only, never on s_tvalid
    assign w_first   = (r_col == '0) && (r_row == '0);
    assign w_row_end = (r_col >= r_wm1);
    assign w_last    = w_row_end && (r_row >= r_hm1);

    // Only a frame's last pixel needs room in the result register
    assign s_tready = !w_last || !r_out_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;

    // Border colour compare
    assign w_colour = w_first ? s_tdata : r_colour;
    assign w_diff   = (s_tdata != w_colour);

    // Bounding box of differing pixels, including this one
    always_comb begin
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (w_diff) begin
            if (!r_found) begin
                n_min_col = r_col;
                n_max_col = r_col;
                n_min_row = r_row;
                n_max_row = r_row;
            end else begin
                if (r_col < r_min_col) n_min_col = r_col;
                if (r_col > r_max_col) n_max_col = r_col;
                if (r_row < r_min_row) n_min_row = r_row;
                if (r_row > r_max_row) n_max_row = r_row;
            end
        end
    end

    // Band counts, masked to the result width
    assign w_top    = fbm_pkg::BAND_W'(n_min_row);
    assign w_bottom = fbm_pkg::BAND_W'(RW'(r_hm1 - n_max_row));
    assign w_left   = fbm_pkg::BAND_W'(n_min_col);
    assign w_right  = fbm_pkg::BAND_W'(CW'(r_wm1 - n_max_col));

    // Clamp of written size values
    always_comb begin
        n_wm1 = r_wm1;
        n_hm1 = r_hm1;
        if (w_cfg_acc) begin
            unique case (i_cfg_index)
                fbm_pkg::REG_FRAME_WIDTH: begin
                    if (i_cfg_data == '0)
                        n_wm1 = '0;
                    else if (32'(i_cfg_data) > 32'(MAX_WIDTH))
                        n_wm1 = CW'(MAX_WIDTH - 1);
                    else
                        n_wm1 = CW'(i_cfg_data - fbm_pkg::CFG_W'(1));
                end
                fbm_pkg::REG_FRAME_HEIGHT: begin
                    if (i_cfg_data == '0)
                        n_hm1 = '0;
                    else if (32'(i_cfg_data) > 32'(MAX_HEIGHT))
                        n_hm1 = RW'(MAX_HEIGHT - 1);
                    else
                        n_hm1 = RW'(i_cfg_data - fbm_pkg::CFG_W'(1));
                end
                default: begin
                    n_wm1 = r_wm1;
                    n_hm1 = r_hm1;
                end
            endcase
        end
    end

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= CW'(RST_WM1);
            r_hm1 <= RW'(RST_HM1);
        end else begin
            r_wm1 <= n_wm1;
            r_hm1 <= n_hm1;
        end
    end

    // Frame state: a config write or the last pixel starts a new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_acc || (w_accept && w_last)) begin
            r_col     <= '0;
            r_row     <= '0;
            r_found   <= 1'b0;
            r_colour  <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
        end else if (w_accept) begin
            r_colour  <= w_colour;
            r_found   <= r_found || w_diff;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            if (w_row_end) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_last) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_out_blank <= !(r_found || w_diff);
            if (r_found || w_diff)
                r_out_data <= {w_colour, w_right, w_left, w_bottom, w_top};
            else
                r_out_data <= {w_colour, {(4 * fbm_pkg::BAND_W){1'b0}}};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_blank;

    // A config write always starts a clean frame
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_acc |=> (r_col == '0) && (r_row == '0) && !r_found)
        else $error("frame state not cleared after config write");

    // Column counter stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wm1)
        else $error("column counter beyond frame width");

    // Bounding box is ordered once a difference is seen
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_min_col <= r_max_col) && (r_min_row <= r_max_row))
        else $error("bounding box out of order");

    // A result appears only after a frame's last pixel is taken
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(w_accept && w_last))
        else $error("result without a completed frame");

endmodule
